// File: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by the top level text_console_writer through scoped names; depends on nothing.
package tcw_pkg;

    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;

    localparam logic [7:0] ATTR_RESET = 8'h0F;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic REG_ATTR = 1'b0;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MAP   = 7'b0000010,
        S_CLEAR = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_MOVE  = 7'b0010000,
        S_RDREQ = 7'b0100000,
        S_LOC   = 7'b1000000
    } t_state;

endpackage

// File: rtl/tcw_wrap_add.sv
// Shared modulo adder: (a + b) wrapped once at LIMIT, for operands below LIMIT.
// Maps screen rows onto the circular row store and steps the row base.
module tcw_wrap_add #(
    parameter int WIDTH = 5,
    parameter int LIMIT = 25
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_sum
);

    logic [WIDTH:0] sum_full;

    always_comb begin
        sum_full = {1'b0, i_a} + {1'b0, i_b};
        if (sum_full >= (WIDTH+1)'(LIMIT)) begin
            o_sum = WIDTH'(sum_full - (WIDTH+1)'(LIMIT));
        end else begin
            o_sum = sum_full[WIDTH-1:0];
        end
    end

endmodule

// File: rtl/tcw_screen_ram.sv
// Character store of the screen: one write port and one registered read port.
// Addressed as {physical row, column}; depends on nothing.
module tcw_screen_ram #(
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// File: rtl/text_console_writer.sv
// Top level of the text console writer: sequencer, cursor, row map and APB register.
// Depends on tcw_pkg, tcw_wrap_add and tcw_screen_ram.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-------------------------------
//  request  | i_action i_char_code i_read_row i_read_col| start & !busy
//  result   | o_cursor_* o_cell_char o_cell_word        | o_valid, one cycle, no stall
//  config   | psel penable pwrite paddr pwdata prdata   | APB, pready always high
//
// A request passes S_MAP, then S_RDREQ for a read inside the screen, S_WRITE for a put
// that stores or erases a cell, S_MOVE for any put, and last S_LOC. o_valid is registered
// from S_LOC; the next request is taken at the edge that ends the o_valid cycle. The first
// write into a row blanked by reset or by a scroll first sweeps it, one store write per
// column. Scroll moves a row base pointer; reset clears the per-row valid bits at once.
// busy is high from the cycle after acceptance through the cycle before o_valid.
module text_console_writer #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [7:0]  i_char_code,
    input  logic [4:0]  i_read_row,
    input  logic [6:0]  i_read_col,

    output logic        o_valid,
    output logic [10:0] o_cursor_location,
    output logic [4:0]  o_cursor_line,
    output logic [6:0]  o_cursor_column,
    output logic [7:0]  o_cell_char,
    output logic [15:0] o_cell_word,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW    = $clog2(SCREEN_COLUMNS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int AW    = RW + CW;
    localparam int LOC_W = $clog2(SCREEN_ROWS * SCREEN_COLUMNS);

    tcw_pkg::t_state r_state, n_state;

    logic [7:0]             r_attr;
    logic [RW-1:0]          r_cur_row, n_cur_row;
    logic [CW-1:0]          r_cur_col, n_cur_col;
    logic [RW-1:0]          r_base, n_base;
    logic [SCREEN_ROWS-1:0] r_row_valid, n_row_valid;
    logic                   r_action;
    logic [7:0]             r_code;
    logic [4:0]             r_rrow;
    logic [6:0]             r_rcol;
    logic [RW-1:0]          r_phys, n_phys;
    logic                   r_inrange, n_inrange;
    logic [CW-1:0]          r_clr_col, n_clr_col;
    logic                   r_valid;
    logic [10:0]            r_loc;
    logic [4:0]             r_line;
    logic [6:0]             r_column;
    logic [7:0]             r_char;

    logic [RW-1:0]  add_a, add_b, add_sum;
    logic           is_bs, is_lf, is_cr, is_prt, need_write, scroll, cfg_write;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]     ram_wdata, ram_rdata, cell_char;
    logic [CW-1:0]  wcol;
    logic [LOC_W-1:0] loc;

    tcw_wrap_add #(
        .WIDTH (RW),
        .LIMIT (SCREEN_ROWS)
    ) u_wrap_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .o_sum (add_sum)
    );

    tcw_screen_ram #(
        .ADDR_W (AW)
    ) u_screen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy    = (r_state != tcw_pkg::S_IDLE);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == tcw_pkg::REG_ATTR) ? {24'd0, r_attr} : 32'd0;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == tcw_pkg::REG_ATTR);

    always_comb begin
        is_bs  = (r_code == tcw_pkg::CHAR_BS);
        is_lf  = (r_code == tcw_pkg::CHAR_LF);
        is_cr  = (r_code == tcw_pkg::CHAR_CR);
        is_prt = r_code inside {[tcw_pkg::PRINT_LO:tcw_pkg::PRINT_HI]};
        need_write = is_prt | (is_bs & (r_cur_col != '0));
        wcol = is_bs ? (r_cur_col - 1'b1) : r_cur_col;
        scroll = (r_cur_row == RW'(SCREEN_ROWS - 2)) &&
                 (is_lf || (is_prt && (r_cur_col == CW'(SCREEN_COLUMNS - 1))));
        loc = LOC_W'(r_cur_row) * LOC_W'(SCREEN_COLUMNS) + LOC_W'(r_cur_col);
        cell_char = (r_action == tcw_pkg::ACT_READ && r_inrange && r_row_valid[r_phys]) ?
                    ram_rdata : tcw_pkg::CHAR_SPACE;
    end

    always_comb begin
        if (r_state == tcw_pkg::S_MOVE) begin
            add_a = r_base;
            add_b = RW'(1);
        end else begin
            add_a = (r_action == tcw_pkg::ACT_READ) ? r_rrow[RW-1:0] : r_cur_row;
            add_b = r_base;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_phys, wcol};
        ram_wdata = is_bs ? tcw_pkg::CHAR_SPACE : r_code;
        ram_re    = (r_state == tcw_pkg::S_RDREQ);
        ram_raddr = {r_phys, r_rcol[CW-1:0]};
        case (r_state)
            tcw_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = {r_phys, r_clr_col};
                ram_wdata = tcw_pkg::CHAR_SPACE;
            end
            tcw_pkg::S_WRITE: begin
                ram_we    = 1'b1;
            end
            default: begin
                ram_we    = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_base      = r_base;
        n_row_valid = r_row_valid;
        n_phys      = r_phys;
        n_inrange   = r_inrange;
        n_clr_col   = r_clr_col;
        case (r_state)
            tcw_pkg::S_IDLE: begin
                if (start) begin
                    n_state = tcw_pkg::S_MAP;
                end
            end
            tcw_pkg::S_MAP: begin
                n_phys    = add_sum;
                n_inrange = ({1'b0, r_rrow} < 6'(SCREEN_ROWS)) &&
                            ({1'b0, r_rcol} < 8'(SCREEN_COLUMNS));
                n_clr_col = '0;
                if (r_action == tcw_pkg::ACT_READ) begin
                    n_state = n_inrange ? tcw_pkg::S_RDREQ : tcw_pkg::S_LOC;
                end else if (!need_write) begin
                    n_state = tcw_pkg::S_MOVE;
                end else if (!r_row_valid[add_sum]) begin
                    n_state = tcw_pkg::S_CLEAR;
                end else begin
                    n_state = tcw_pkg::S_WRITE;
                end
            end
            tcw_pkg::S_CLEAR: begin
                n_clr_col = r_clr_col + 1'b1;
                if (r_clr_col == CW'(SCREEN_COLUMNS - 1)) begin
                    n_row_valid[r_phys] = 1'b1;
                    n_state = tcw_pkg::S_WRITE;
                end
            end
            tcw_pkg::S_WRITE: begin
                n_state = tcw_pkg::S_MOVE;
            end
            tcw_pkg::S_MOVE: begin
                n_state = tcw_pkg::S_LOC;
                if (is_bs) begin
                    if (r_cur_col != '0) begin
                        n_cur_col = r_cur_col - 1'b1;
                    end
                end else if (is_cr) begin
                    n_cur_col = '0;
                end else if (is_lf || is_prt) begin
                    if (is_prt && (r_cur_col != CW'(SCREEN_COLUMNS - 1))) begin
                        n_cur_col = r_cur_col + 1'b1;
                    end else begin
                        n_cur_col = '0;
                        if (scroll) begin
                            n_base = add_sum;
                            n_row_valid[r_base] = 1'b0;
                        end else begin
                            n_cur_row = r_cur_row + 1'b1;
                        end
                    end
                end
            end
            tcw_pkg::S_RDREQ: begin
                n_state = tcw_pkg::S_LOC;
            end
            tcw_pkg::S_LOC: begin
                n_state = tcw_pkg::S_IDLE;
            end
            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_IDLE;
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_base      <= '0;
            r_row_valid <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_base      <= n_base;
            r_row_valid <= n_row_valid;
            r_valid     <= (r_state == tcw_pkg::S_LOC);
            if (cfg_write) begin
                r_attr <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phys    <= n_phys;
        r_inrange <= n_inrange;
        r_clr_col <= n_clr_col;
        if (r_state == tcw_pkg::S_IDLE && start) begin
            r_action <= i_action;
            r_code   <= i_char_code;
            r_rrow   <= i_read_row;
            r_rcol   <= i_read_col;
        end
        if (r_state == tcw_pkg::S_LOC) begin
            r_loc    <= 11'(loc);
            r_line   <= 5'(r_cur_row);
            r_column <= 7'(r_cur_col);
            r_char   <= cell_char;
        end
    end

    assign o_valid           = r_valid;
    assign o_cursor_location = r_loc;
    assign o_cursor_line     = r_line;
    assign o_cursor_column   = r_column;
    assign o_cell_char       = r_char;
    assign o_cell_word       = {r_attr, r_char};

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_row <= RW'(SCREEN_ROWS - 2))
        else $error("cursor row reached the last screen row");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col <= CW'(SCREEN_COLUMNS - 1))
        else $error("cursor column beyond screen");

    a_result_after_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == tcw_pkg::S_LOC))
        else $error("result strobe without a finished request");

    a_scroll_blanks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::S_MOVE && scroll) |=> !r_row_valid[$past(r_base)])
        else $error("scroll left the new last row valid");

    a_write_row_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::S_WRITE) |-> r_row_valid[r_phys])
        else $error("cell write into an unswept row");

endmodule
